>>> hw/rtl/spq_pkg.sv
// Shared constants and control types for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // apply the captured request and latch its result
  } spq_cmd_t;

endpackage

>>> hw/rtl/spq_ctrl.sv
// Controller state machine for the sorted priority queue.
`timescale 1ns / 1ps

module spq_ctrl import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output spq_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  // Result slot frees when empty or when its result leaves this cycle.
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o.load = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec = (state_q == S_EXEC) && slot_free;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_EXEC) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/spq_dpath.sv
// Datapath: request registers, compare-and-shift entry cells and result registers.
`timescale 1ns / 1ps

module spq_dpath import spq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_cmd_t            cmd_i,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic signed [KEY_W-1:0] key_value_i,
  output logic                op_ok_o,
  output logic                store_full_o,
  output logic signed [KEY_W-1:0] head_value_o,
  output logic                queue_empty_o,
  output logic [COUNT_W-1:0]  entry_count_o
);

  logic [MODE_W-1:0]       mode_q;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] ent_q [CAPACITY];
  logic signed [KEY_W-1:0] ent_d [CAPACITY];
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CAPACITY-1:0]     vld, lt, eq;

  logic is_ins, is_rem, is_find, ins_ok, found, ok_d, full_d;
  logic signed [KEY_W-1:0] head_d;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  logic                    ok_q, full_q, empty_q;
  logic signed [KEY_W-1:0] head_q;
  logic [COUNT_W-1:0]      count_q;

  assign is_ins  = (mode_q == MODE_INSERT);
  assign is_rem  = (mode_q == MODE_REMOVE);
  assign is_find = (mode_q == MODE_FIND);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    assign vld[i] = (CNT_W'(i) < cnt_q);
    assign lt[i]  = vld[i] && (ent_q[i] < key_q);
    assign eq[i]  = vld[i] && (ent_q[i] == key_q);
  end

  assign ins_ok = is_ins && (cnt_q < CNT_W'(CAPACITY));
  assign found  = |eq;

  // Each cell either holds, takes the key, takes its lower neighbor (insert)
  // or takes its upper neighbor (remove). Sorted order makes "at or past the
  // slot" a local test on the cell's own compare.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      ent_d[i] = ent_q[i];
      if (ins_ok && !lt[i]) begin
        if (i == 0) begin
          ent_d[i] = key_q;
        end else if (lt[(i == 0) ? 0 : i-1]) begin
          ent_d[i] = key_q;
        end else begin
          ent_d[i] = ent_q[(i == 0) ? 0 : i-1];
        end
      end else if (is_rem && found && vld[i] && !lt[i]) begin
        ent_d[i] = ent_q[(i == CAPACITY-1) ? i : i+1];
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ins_ok) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (is_rem && found) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
    ok_d   = ins_ok || ((is_rem || is_find) && found);
    full_d = is_ins && !ins_ok;
    head_d = (cnt_d != '0) ? ent_d[0] : '0;
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q  <= key_value_i;
    end
    if (cmd_i.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        ent_q[i] <= ent_d[i];
      end
      ok_q    <= ok_d;
      full_q  <= full_d;
      head_q  <= head_d;
      empty_q <= (cnt_d == '0);
      count_q <= cnt_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      cnt_q <= cnt_d;
    end
  end

  assign op_ok_o       = ok_q;
  assign store_full_o  = full_q;
  assign head_value_o  = head_q;
  assign queue_empty_o = empty_q;
  assign entry_count_o = count_q;

endmodule

>>> hw/rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: controller plus datapath.
`timescale 1ns / 1ps
//
// Sorted priority queue of up to CAPACITY signed 32-bit values, ascending.
// Input channel: in_valid_i / in_stall_o with mode_i (insert, remove, find)
// and key_value_i. Output channel: out_valid_o / out_stall_i with op_ok_o,
// store_full_o, head_value_o, queue_empty_o and entry_count_o.
// Every request yields exactly one result, in request order.
// The controller captures a request into the request registers, then
// applies it in one pass over the compare-and-shift entry cells and
// latches its result; it takes no new request until that one is applied.
// Capture the next request while an earlier result still waits in the output
// register; hold the apply step while that result is stalled, so a stalled
// receiver only delays later results and nothing is dropped.
// Insert into a full store is refused (store_full_o set, op_ok_o clear).
// Reset (rst_ni low, asynchronous) empties the store and clears the output
// valid; no clearing pass runs, entries past the count never reach a result.
// head_value_o reads 0 when the store is empty.
//
module sorted_priority_queue_unit import spq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic signed [KEY_W-1:0] key_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    op_ok_o,
  output logic                    store_full_o,
  output logic signed [KEY_W-1:0] head_value_o,
  output logic                    queue_empty_o,
  output logic [COUNT_W-1:0]      entry_count_o
);

  spq_cmd_t cmd;

  // Sequence capture and apply, own the output valid.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Hold the sorted entries and the result fields.
  spq_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (mode_i),
    .key_value_i   (key_value_i),
    .op_ok_o       (op_ok_o),
    .store_full_o  (store_full_o),
    .head_value_o  (head_value_o),
    .queue_empty_o (queue_empty_o),
    .entry_count_o (entry_count_o)
  );

endmodule

>>> hw/rtl/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               op_ok_o,
  input logic               store_full_o,
  input logic               queue_empty_o,
  input logic [COUNT_W-1:0] entry_count_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One request at a time: an accepted request blocks the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one in flight");

  // A refused insert never reports success.
  a_full_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_full_o |-> !op_ok_o)
    else $error("full and ok together");

  // A full refusal only happens with a nonempty store.
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_full_o |-> !queue_empty_o)
    else $error("full reported on empty store");

  // The empty flag agrees with the entry count.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (queue_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with entry count");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .op_ok_o       (op_ok_o),
  .store_full_o  (store_full_o),
  .queue_empty_o (queue_empty_o),
  .entry_count_o (entry_count_o)
);

>>> tb/sv/tb_sorted_priority_queue_unit.sv
// Testbench for the sorted priority queue unit: directed and random requests vs. a predictor.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  // Unused mode code: the block must leave the store alone and still answer.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic               ok;
    logic               full;
    logic [KEY_W-1:0]   head;
    logic               empty;
    logic [COUNT_W-1:0] count;
  } queue_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [MODE_W-1:0]       mode_i;
  logic signed [KEY_W-1:0] key_value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    op_ok_o;
  logic                    store_full_o;
  logic signed [KEY_W-1:0] head_value_o;
  logic                    queue_empty_o;
  logic [COUNT_W-1:0]      entry_count_o;

  // Predicted store contents, kept in ascending order.
  logic signed [KEY_W-1:0] held_keys [CAPACITY];
  int                      held_count = 0;

  queue_result_t expected_results [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int stall_hold_left = 0;
  int error_count = 0;
  int checked_count = 0;
  int refused_count = 0;
  int mode_tally [4] = '{0, 0, 0, 0};

  sorted_priority_queue_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .key_value_i   (key_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .op_ok_o       (op_ok_o),
    .store_full_o  (store_full_o),
    .head_value_o  (head_value_o),
    .queue_empty_o (queue_empty_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Index of the first held entry equal to the key, or held_count if absent.
  function automatic int locate_key(input logic signed [KEY_W-1:0] key);
    int idx;
    for (idx = 0; idx < held_count; idx++) begin
      if (held_keys[idx] == key) break;
    end
    return idx;
  endfunction

  // Apply one request to the predicted store and return the result it should give.
  function automatic queue_result_t apply_queue_request(input logic [MODE_W-1:0] mode,
                                                        input logic signed [KEY_W-1:0] key);
    queue_result_t res;
    int            pos;
    int            idx;
    res = '0;
    case (mode)
      MODE_INSERT: begin
        if (held_count >= CAPACITY) begin
          res.full = 1'b1;
        end else begin
          // Place ahead of equal values: stop at the first entry not below the key.
          pos = 0;
          while (pos < held_count && held_keys[pos] < key) pos++;
          for (idx = held_count; idx > pos; idx--) held_keys[idx] = held_keys[idx-1];
          held_keys[pos] = key;
          held_count++;
          res.ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        pos = locate_key(key);
        if (pos < held_count) begin
          for (idx = pos; idx + 1 < held_count; idx++) held_keys[idx] = held_keys[idx+1];
          held_count--;
          res.ok = 1'b1;
        end
      end
      MODE_FIND: begin
        res.ok = (locate_key(key) < held_count);
      end
      default: begin
      end
    endcase
    res.head  = (held_count > 0) ? held_keys[0] : '0;
    res.empty = (held_count == 0);
    res.count = COUNT_W'(held_count);
    return res;
  endfunction

  // Offer one request at the falling edge and hold it until the block takes it.
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic signed [KEY_W-1:0] key);
    queue_result_t res;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    key_value_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    res = apply_queue_request(mode, key);
    expected_results.push_back(res);
    mode_tally[mode]++;
    if (res.full) refused_count++;
  endtask

  // Favor held keys and a narrow band so that removes, finds and duplicates hit.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35 && held_count > 0) return held_keys[$urandom_range(0, held_count - 1)];
    if (r < 60) return KEY_W'(int'($urandom_range(0, 15)) - 8);
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // Lean toward inserts when the store is low and toward removes when it is high.
  function automatic logic [MODE_W-1:0] pick_mode();
    int unsigned r;
    int          ins_weight;
    r = $urandom_range(0, 99);
    ins_weight = (held_count < 4) ? 55 : (held_count > 12) ? 25 : 40;
    if (r < 4) return MODE_UNUSED;
    if (r < 4 + ins_weight) return MODE_INSERT;
    if (r < 4 + ins_weight + (96 - ins_weight) / 2) return MODE_REMOVE;
    return MODE_FIND;
  endfunction

  task automatic test_empty_and_basic();
    idle_pct  = 0;
    stall_pct = 0;
    // Empty store: lookups miss, head reads zero.
    send_request(MODE_FIND, '0);
    send_request(MODE_REMOVE, KEY_MIN);
    send_request(MODE_UNUSED, KEY_MAX);
    send_request(MODE_INSERT, KEY_MAX);
    send_request(MODE_INSERT, KEY_MIN);
    send_request(MODE_INSERT, '0);
    send_request(MODE_INSERT, '0);
    send_request(MODE_INSERT, '1);
    send_request(MODE_FIND, '0);
    send_request(MODE_FIND, KEY_W'(5));
    send_request(MODE_REMOVE, '0);
    send_request(MODE_REMOVE, KEY_W'(7));
    send_request(MODE_UNUSED, KEY_MIN);
  endtask

  task automatic test_fill_to_capacity();
    idle_pct  = 0;
    stall_pct = 0;
    while (held_count < CAPACITY) send_request(MODE_INSERT, $urandom);
    // Refuse an insert on a full store, even one that would become the head.
    send_request(MODE_INSERT, KEY_MIN);
  endtask

  task automatic test_output_hold();
    idle_pct  = 0;
    stall_pct = 0;
    // Hold the receiver off while requests keep coming, so the input backs up.
    stall_hold_left = HOLD_CYCLES;
    repeat (30) send_request(pick_mode(), pick_key());
  endtask

  task automatic test_random_traffic(input int in_idle, input int out_stall,
                                     input int n_items);
    int sent;
    int kind;
    idle_pct  = in_idle;
    stall_pct = out_stall;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        // Fill up, then one refused insert.
        while (held_count < CAPACITY) begin
          send_request(MODE_INSERT, pick_key());
          sent++;
        end
        send_request(MODE_INSERT, pick_key());
        sent++;
      end else if (kind < 30) begin
        // Drain through held keys, then one miss on the empty store.
        while (held_count > 0) begin
          send_request(MODE_REMOVE, held_keys[$urandom_range(0, held_count - 1)]);
          sent++;
        end
        send_request(MODE_REMOVE, pick_key());
        sent++;
      end else begin
        repeat ($urandom_range(4, 10)) begin
          send_request(pick_mode(), pick_key());
          sent++;
        end
      end
    end
  endtask

  // Drive the receiver stall at the falling edge; a pending hold-off wins.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_hold_left > 0) begin
        out_stall_i <= 1'b1;
        stall_hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    queue_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with no request outstanding", $realtime);
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (op_ok_o !== want.ok || store_full_o !== want.full ||
            head_value_o !== want.head || queue_empty_o !== want.empty ||
            entry_count_o !== want.count) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"%0t: mismatch exp ok=%0b full=%0b head=%0d empty=%0b count=%0d",
                      " | got ok=%0b full=%0b head=%0d empty=%0b count=%0d"},
                     $realtime, want.ok, want.full, $signed(want.head), want.empty,
                     want.count, op_ok_o, store_full_o, head_value_o, queue_empty_o,
                     entry_count_o);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_INSERT;
    key_value_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_and_basic();
    test_fill_to_capacity();
    test_random_traffic(0, 0, 200);
    test_output_hold();
    test_random_traffic(58, 0, 200);
    test_random_traffic(0, 58, 200);
    test_random_traffic(29, 29, 200);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display({"Sent %0d insert, %0d remove, %0d find, %0d unused-code requests;",
              " %0d inserts refused."},
             mode_tally[MODE_INSERT], mode_tally[MODE_REMOVE], mode_tally[MODE_FIND],
             mode_tally[MODE_UNUSED], refused_count);
    $display("Checked %0d results across idle, sender-gap, receiver-stall and hold-off phases.",
             checked_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sorted_priority_queue_unit.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_dpath.sv
hw/rtl/sorted_priority_queue_unit.sv
hw/rtl/spq_checker.sv
tb/sv/tb_sorted_priority_queue_unit.sv
